// ----- hw/rtl/mbs_pkg.sv -----
// Shared types and constants for the maze backtracker step block.
// Request/result payloads, controller-datapath command and status structs.
// No dependencies.
`default_nettype none

package mbs_pkg;

    typedef struct packed {
        logic       action;
        logic [1:0] choice;
    } mbs_req_t;

    typedef struct packed {
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic       carved;
        logic [1:0] carved_dir;
        logic       backtracked;
        logic       done_res;
    } mbs_res_t;

    localparam int CFG_DATA_W = 7;

    localparam logic REG_MAZE_WIDTH  = 1'b0;
    localparam logic REG_MAZE_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 7'd16;

    localparam logic ACTION_STEP    = 1'b0;
    localparam logic ACTION_RESTART = 1'b1;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam int         NUM_SLOTS  = 5;
    localparam logic [2:0] SLOT_CUR   = 3'd0;
    localparam logic [2:0] SLOT_UP    = 3'd1;
    localparam logic [2:0] SLOT_LEFT  = 3'd2;
    localparam logic [2:0] SLOT_DOWN  = 3'd3;
    localparam logic [2:0] SLOT_RIGHT = 3'd4;

    localparam logic [3:0] WALLS_ALL = 4'hF;

    typedef struct packed {
        logic       accept;
        logic       restart;
        logic       clr_step;
        logic       rd_issue;
        logic [2:0] rd_slot;
        logic       cap;
        logic [2:0] cap_slot;
        logic       wr_cur;
        logic       wr_nxt;
        logic       pop_rd;
        logic       pop_load;
        logic       set_done;
        logic       load_out;
    } mbs_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic walk_done;
        logic carve;
        logic stack_empty;
    } mbs_sts_t;

    // Candidate order is up, left, down, right.
    function automatic logic [1:0] cand_dir(input logic [1:0] k);
        logic [1:0] d;
        unique case (k)
            2'd0:    d = DIR_UP;
            2'd1:    d = DIR_LEFT;
            2'd2:    d = DIR_DOWN;
            default: d = DIR_RIGHT;
        endcase
        return d;
    endfunction

    // choice modulo candidate count, count in 1..4
    function automatic logic [1:0] pick_index(input logic [1:0] choice, input logic [2:0] n);
        logic [1:0] p;
        case (n)
            3'd2:    p = {1'b0, choice[0]};
            3'd3:    p = (choice == 2'd3) ? 2'd0 : choice;
            3'd4:    p = choice;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mbs_datapath.sv -----
// Datapath of the maze backtracker step: grid registers, cell memory
// (visited and walls), path stack, current cell and result register.
// Depends on mbs_pkg; driven by mbs_ctrl through mbs_cmd_t.
`default_nettype none

module mbs_datapath #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mbs_pkg::mbs_cmd_t               cmd,
    output mbs_pkg::mbs_sts_t                    sts,
    input  wire mbs_pkg::mbs_req_t               req,
    output mbs_pkg::mbs_res_t                    res,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [mbs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import mbs_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int CW    = AW + 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP  = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int HCMP  = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;

    typedef struct packed {
        logic       visited;
        logic [3:0] walls;
    } cell_t;

    logic [CFG_DATA_W-1:0] maze_width_reg;
    logic [CFG_DATA_W-1:0] maze_height_reg;
    logic [WW-1:0]         w_eff;
    logic [HW-1:0]         h_eff;

    logic [XW-1:0]         cur_x_reg;
    logic [YW-1:0]         cur_y_reg;
    logic [AW-1:0]         cur_addr;
    logic [CW-1:0]         stk_cnt_reg;
    logic [CW-1:0]         stk_dec;
    logic                  done_reg;
    logic [AW-1:0]         clr_cnt_reg;

    cell_t                 cell_mem [DEPTH];
    cell_t                 mem_rdata_reg;
    logic [AW-1:0]         rd_addr;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    cell_t                 mem_wdata;

    logic [AW-1:0]         stk_mem [DEPTH];
    logic [AW-1:0]         stk_rdata_reg;
    logic                  push;

    cell_t                 slot_reg [NUM_SLOTS];
    logic [1:0]            choice_reg;
    logic                  carve_reg;
    logic [1:0]            dir_reg;
    logic [1:0]            sel_reg;
    logic                  back_reg;
    mbs_res_t              res_reg;

    logic [WW-1:0]         xe;
    logic [HW-1:0]         ye;
    logic [3:0]            nbr_ok;
    logic [AW-1:0]         nbr_addr [4];
    logic [3:0]            cand;
    logic [2:0]            n_cand;
    logic [1:0]            pick;
    logic [1:0]            sel_now;
    logic [2:0]            seen;
    logic                  carve_now;
    logic [1:0]            dir_now;
    logic [2:0]            nxt_slot;
    cell_t                 nxt_cell;

    // Clamp grid size to 1..MAX
    always_comb
    begin
        if (maze_width_reg == '0)
            w_eff = WW'(1);
        else if (WCMP'(maze_width_reg) > WCMP'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(maze_width_reg);
        if (maze_height_reg == '0)
            h_eff = HW'(1);
        else if (HCMP'(maze_height_reg) > HCMP'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(maze_height_reg);
    end

    assign cur_addr = {cur_y_reg, cur_x_reg};
    assign xe       = WW'(cur_x_reg);
    assign ye       = HW'(cur_y_reg);

    // Neighbors in order up, left, down, right
    always_comb
    begin
        nbr_ok[0] = (cur_y_reg != '0) && (xe < w_eff) && ((ye - HW'(1)) < h_eff);
        nbr_ok[1] = (cur_x_reg != '0) && ((xe - WW'(1)) < w_eff) && (ye < h_eff);
        nbr_ok[2] = ((ye + HW'(1)) < h_eff) && (xe < w_eff);
        nbr_ok[3] = ((xe + WW'(1)) < w_eff) && (ye < h_eff);
        nbr_addr[0] = {cur_y_reg - YW'(1), cur_x_reg};
        nbr_addr[1] = {cur_y_reg, cur_x_reg - XW'(1)};
        nbr_addr[2] = {cur_y_reg + YW'(1), cur_x_reg};
        nbr_addr[3] = {cur_y_reg, cur_x_reg + XW'(1)};
    end

    always_comb
    begin
        case (cmd.rd_slot)
            SLOT_UP:    rd_addr = nbr_addr[0];
            SLOT_LEFT:  rd_addr = nbr_addr[1];
            SLOT_DOWN:  rd_addr = nbr_addr[2];
            SLOT_RIGHT: rd_addr = nbr_addr[3];
            default:    rd_addr = cur_addr;
        endcase
    end

    // Pick among unvisited neighbors
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            cand[k] = nbr_ok[k] && !slot_reg[k + 1].visited;
        n_cand = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
        pick   = pick_index(choice_reg, n_cand);
        seen    = '0;
        sel_now = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (cand[k])
            begin
                if (seen == {1'b0, pick})
                    sel_now = 2'(k);
                seen = seen + 3'd1;
            end
        end
        carve_now = (n_cand != '0);
        dir_now   = cand_dir(sel_now);
    end

    assign nxt_slot = 3'(sel_reg) + 3'd1;
    assign nxt_cell = slot_reg[nxt_slot];
    assign push     = cmd.wr_cur && !slot_reg[SLOT_CUR].visited && (stk_cnt_reg < CW'(CELLS));
    assign stk_dec  = stk_cnt_reg - CW'(1);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = '{visited: 1'b0, walls: WALLS_ALL};
        if (cmd.clr_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
        end
        else if (cmd.wr_cur)
        begin
            mem_we          = 1'b1;
            mem_wdata.visited = 1'b1;
            mem_wdata.walls = slot_reg[SLOT_CUR].walls
                              & ~(carve_now ? (4'd1 << dir_now) : 4'd0);
        end
        else if (cmd.wr_nxt)
        begin
            mem_we            = 1'b1;
            mem_waddr         = nbr_addr[sel_reg];
            mem_wdata.visited = nxt_cell.visited;
            mem_wdata.walls   = nxt_cell.walls & ~(4'd1 << (dir_reg + 2'd2));
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[mem_waddr] <= mem_wdata;
        if (cmd.rd_issue)
            mem_rdata_reg <= cell_mem[rd_addr];
        if (push)
            stk_mem[stk_cnt_reg[AW-1:0]] <= cur_addr;
        if (cmd.pop_rd)
            stk_rdata_reg <= stk_mem[stk_dec[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maze_width_reg  <= DIM_RESET;
            maze_height_reg <= DIM_RESET;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            stk_cnt_reg     <= '0;
            done_reg        <= 1'b0;
            clr_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAZE_WIDTH:  maze_width_reg  <= cfg_wdata;
                    REG_MAZE_HEIGHT: maze_height_reg <= cfg_wdata;
                    default:         maze_width_reg  <= maze_width_reg;
                endcase
            end
            if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (cmd.restart)
            begin
                cur_x_reg   <= '0;
                cur_y_reg   <= '0;
                stk_cnt_reg <= '0;
                done_reg    <= 1'b0;
                clr_cnt_reg <= '0;
            end
            if (push)
                stk_cnt_reg <= stk_cnt_reg + CW'(1);
            if (cmd.wr_nxt)
                {cur_y_reg, cur_x_reg} <= nbr_addr[sel_reg];
            if (cmd.pop_rd)
                stk_cnt_reg <= stk_dec;
            if (cmd.pop_load)
                {cur_y_reg, cur_x_reg} <= stk_rdata_reg;
            if (cmd.set_done)
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            choice_reg <= req.choice;
            carve_reg  <= 1'b0;
            dir_reg    <= DIR_UP;
            back_reg   <= 1'b0;
        end
        if (cmd.cap)
            slot_reg[cmd.cap_slot] <= mem_rdata_reg;
        if (cmd.wr_cur)
        begin
            carve_reg <= carve_now;
            dir_reg   <= carve_now ? dir_now : DIR_UP;
            sel_reg   <= sel_now;
        end
        if (cmd.pop_load)
            back_reg <= 1'b1;
        if (cmd.load_out)
        begin
            res_reg.cell_x      <= 6'(cur_x_reg);
            res_reg.cell_y      <= 6'(cur_y_reg);
            res_reg.carved      <= carve_reg;
            res_reg.carved_dir  <= dir_reg;
            res_reg.backtracked <= back_reg;
            res_reg.done_res    <= done_reg;
        end
    end

    assign res = res_reg;

    always_comb
    begin
        sts.clr_last    = (clr_cnt_reg == '1);
        sts.walk_done   = done_reg;
        sts.carve       = carve_reg;
        sts.stack_empty = (stk_cnt_reg == '0);
    end

    a_stk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stk_cnt_reg <= CW'(CELLS))
        else $error("path stack count beyond cell count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_rd |-> (stk_cnt_reg != '0))
        else $error("pop from empty path stack");

    a_carve_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_nxt |-> (carve_reg && !nxt_cell.visited))
        else $error("carve into a visited cell");

endmodule

`default_nettype wire

// ----- hw/rtl/mbs_ctrl.sv -----
// Controller of the maze backtracker step: sequences the clearing pass,
// neighbor reads, cell writes, stack pop and result hand-off.
// Depends on mbs_pkg; commands mbs_datapath.
`default_nettype none

module mbs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic              req_action,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output mbs_pkg::mbs_cmd_t      cmd,
    input  wire mbs_pkg::mbs_sts_t sts
);
    import mbs_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RST,
        S_READ,
        S_LAST,
        S_WCUR,
        S_WNXT,
        S_POP,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] rd_cnt_reg, rd_cnt_next;
    logic       restart_reg, restart_next;
    logic       res_valid_reg, res_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        restart_next   = restart_reg;
        res_valid_next = res_valid_reg && res_stall;
        cmd            = '0;
        cmd.rd_slot    = rd_cnt_reg;
        cmd.cap_slot   = rd_cnt_reg - 3'd1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept   = 1'b1;
                    restart_next = (req_action == ACTION_RESTART);
                    rd_cnt_next  = SLOT_CUR;
                    if (req_action == ACTION_RESTART)
                        state_next = S_RST;
                    else if (sts.walk_done)
                        state_next = S_OUT;
                    else
                        state_next = S_READ;
                end
            end
            S_RST:
            begin
                cmd.restart = 1'b1;
                state_next  = S_OUT;
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                cmd.cap      = (rd_cnt_reg != SLOT_CUR);
                if (rd_cnt_reg == SLOT_RIGHT)
                    state_next = S_LAST;
                else
                    rd_cnt_next = rd_cnt_reg + 3'd1;
            end
            S_LAST:
            begin
                cmd.cap      = 1'b1;
                cmd.cap_slot = SLOT_RIGHT;
                state_next   = S_WCUR;
            end
            S_WCUR:
            begin
                cmd.wr_cur = 1'b1;
                state_next = S_WNXT;
            end
            S_WNXT:
            begin
                if (sts.carve)
                begin
                    cmd.wr_nxt = 1'b1;
                    state_next = S_OUT;
                end
                else if (!sts.stack_empty)
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POP;
                end
                else
                begin
                    cmd.set_done = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_POP:
            begin
                cmd.pop_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    cmd.load_out   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = restart_reg ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rd_cnt_reg    <= SLOT_CUR;
            restart_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            restart_reg   <= restart_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!res_valid_reg || !res_stall))
        else $error("result overwritten while held");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_step, cmd.wr_cur, cmd.wr_nxt}))
        else $error("cell memory write conflict");

    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (rd_cnt_reg <= SLOT_RIGHT))
        else $error("neighbor read slot out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/maze_backtracker_step.sv -----
// Top level of the maze backtracker step block.
// Instantiates mbs_ctrl and mbs_datapath; depends on mbs_pkg.
//
// One request moves a randomized depth-first walk by one step, or restarts
// it. A walk step reads the current cell and its four neighbors, writes the
// current cell, then writes the carved neighbor or pops the path stack (an
// extra state when the walk backtracks) before it loads its result, and the
// next request is taken in the cycle after the load. The cell memory has one
// read port, so the current cell and its four neighbors are read one per
// cycle, and the two cells that share a removed wall are written one after
// the other. A step after the walk is done skips the reads and writes and
// goes straight to its result load. A restart loads its result and then runs
// a clearing pass over the whole cell memory, 2**(clog2(MAX_WIDTH)+
// clog2(MAX_HEIGHT)) cells (4096 at the defaults), during which no request
// is taken; the same pass runs after reset. While an earlier result is still
// held by res_stall, the new result waits and the block takes no request.
// Configuration writes are taken at any time.
`default_nettype none

module maze_backtracker_step #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire mbs_pkg::mbs_req_t              req,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output mbs_pkg::mbs_res_t                   res,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [mbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import mbs_pkg::*;

    mbs_cmd_t cmd;
    mbs_sts_t sts;

    mbs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_action (req.action),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .cmd        (cmd),
        .sts        (sts)
    );

    mbs_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

`default_nettype wire

// ----- test/tb_maze_backtracker_step.sv -----
// Self-checking testbench for maze_backtracker_step: drives walk-step and restart requests,
// predicts every result with its own maze walk model and compares it field by field.
// Depends on mbs_pkg and the maze_backtracker_step RTL.
`default_nettype none

module tb_maze_backtracker_step;

    import mbs_pkg::*;

    localparam int GRID_W      = 64;
    localparam int GRID_H      = 64;
    localparam int CELLS       = GRID_W * GRID_H;
    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES = 20;
    localparam int PRINT_CAP   = 30;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    mbs_req_t              req       = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    mbs_res_t              res;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = REG_MAZE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = DIM_RESET;

    mbs_req_t step_requests[$];
    mbs_res_t walk_results_due[$];
    logic     req_fire = 1'b0;

    int send_idle_pct = 36;
    int recv_idle_pct = 63;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int result_count  = 0;
    int mismatches    = 0;

    // walk model state
    logic [CFG_DATA_W-1:0] cols_reg = DIM_RESET;
    logic [CFG_DATA_W-1:0] rows_reg = DIM_RESET;
    bit                    visited_map [CELLS];
    logic [11:0]           path_mem [CELLS];
    int                    path_depth    = 0;
    logic [11:0]           cur_cell      = '0;
    bit                    walk_finished = 1'b0;

    maze_backtracker_step #(
        .MAX_WIDTH  (GRID_W),
        .MAX_HEIGHT (GRID_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic mbs_res_t walk_step(input mbs_req_t r);
        mbs_res_t   o;
        int         w;
        int         h;
        int         x;
        int         y;
        int         nx;
        int         ny;
        int         n;
        int         pick;
        int         open_cell [4];
        logic [1:0] open_dir [4];
        logic [1:0] d;
        o = '0;
        n = 0;
        if (r.action == ACTION_RESTART) begin
            for (int i = 0; i < CELLS; i++)
                visited_map[i] = 1'b0;
            path_depth    = 0;
            cur_cell      = '0;
            walk_finished = 1'b0;
        end else if (!walk_finished) begin
            w = int'(cols_reg);
            if (w == 0)
                w = 1;
            else if (w > GRID_W)
                w = GRID_W;
            h = int'(rows_reg);
            if (h == 0)
                h = 1;
            else if (h > GRID_H)
                h = GRID_H;
            x = cur_cell % GRID_W;
            y = cur_cell / GRID_W;
            if (!visited_map[cur_cell]) begin
                visited_map[cur_cell] = 1'b1;
                if (path_depth < CELLS) begin
                    path_mem[path_depth] = cur_cell;
                    path_depth++;
                end
            end
            for (int k = 0; k < 4; k++) begin
                nx = x;
                ny = y;
                case (k)
                    0:       begin ny = y - 1; d = DIR_UP;    end
                    1:       begin nx = x - 1; d = DIR_LEFT;  end
                    2:       begin ny = y + 1; d = DIR_DOWN;  end
                    default: begin nx = x + 1; d = DIR_RIGHT; end
                endcase
                if (nx >= 0 && ny >= 0 && nx < w && ny < h) begin
                    if (!visited_map[ny * GRID_W + nx]) begin
                        open_cell[n] = ny * GRID_W + nx;
                        open_dir[n]  = d;
                        n++;
                    end
                end
            end
            if (n > 0) begin
                pick         = int'(r.choice) % n;
                cur_cell     = 12'(open_cell[pick]);
                o.carved     = 1'b1;
                o.carved_dir = open_dir[pick];
            end else if (path_depth > 0) begin
                path_depth--;
                cur_cell      = path_mem[path_depth];
                o.backtracked = 1'b1;
            end else begin
                walk_finished = 1'b1;
            end
        end
        x = cur_cell % GRID_W;
        y = cur_cell / GRID_W;
        o.cell_x   = x[5:0];
        o.cell_y   = y[5:0];
        o.done_res = walk_finished;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     result_count, what, got, want);
    endtask

    task automatic queue_req(input logic action, input logic [1:0] choice);
        mbs_req_t r;
        r.action = action;
        r.choice = choice;
        step_requests.push_back(r);
    endtask

    task automatic write_reg(input logic idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MAZE_WIDTH)
            cols_reg = CFG_DATA_W'(val);
        else
            rows_reg = CFG_DATA_W'(val);
    endtask

    task automatic drain();
        while (step_requests.size() != 0 || req_valid || walk_results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic run_walk(input int cols, input int rows, input int steps,
                            input bit fresh, input int restart_per_mille);
        mbs_req_t r;
        write_reg(REG_MAZE_WIDTH, cols);
        write_reg(REG_MAZE_HEIGHT, rows);
        if (fresh)
            queue_req(ACTION_RESTART, 2'($urandom_range(3)));
        else
            hold_token++;
        repeat (steps) begin
            r.action = ($urandom_range(999) < restart_per_mille) ? ACTION_RESTART : ACTION_STEP;
            r.choice = 2'($urandom_range(3));
            step_requests.push_back(r);
        end
        drain();
    endtask

    // request driver
    always @(negedge clk) begin
        if (rst_n && (!req_valid || req_fire)) begin
            if (step_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req       <= step_requests.pop_front();
                req_valid <= 1'b1;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge clk) begin
        if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_stall <= 1'b1;
        end else begin
            res_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin : monitor
        mbs_res_t want;
        req_fire <= rst_n && req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall)
            walk_results_due.push_back(walk_step(req));
        if (rst_n && res_valid && !res_stall) begin
            if (walk_results_due.size() == 0) begin
                report_mismatch("result with none pending", 1, 0);
            end else begin
                want = walk_results_due.pop_front();
                if (res.cell_x !== want.cell_x)
                    report_mismatch("cell_x", res.cell_x, want.cell_x);
                if (res.cell_y !== want.cell_y)
                    report_mismatch("cell_y", res.cell_y, want.cell_y);
                if (res.carved !== want.carved)
                    report_mismatch("carved", res.carved, want.carved);
                if (res.carved_dir !== want.carved_dir)
                    report_mismatch("carved_dir", res.carved_dir, want.carved_dir);
                if (res.backtracked !== want.backtracked)
                    report_mismatch("backtracked", res.backtracked, want.backtracked);
                if (res.done_res !== want.done_res)
                    report_mismatch("done_res", res.done_res, want.done_res);
            end
            result_count++;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("FAIL maze_backtracker_step");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // reset dimensions, then single cell
        queue_req(ACTION_STEP, 2'd0);
        queue_req(ACTION_STEP, 2'd3);
        queue_req(ACTION_RESTART, 2'd1);
        drain();
        write_reg(REG_MAZE_WIDTH, 1);
        write_reg(REG_MAZE_HEIGHT, 1);
        queue_req(ACTION_STEP, 2'd0);
        queue_req(ACTION_STEP, 2'd3);
        queue_req(ACTION_STEP, 2'd2);
        queue_req(ACTION_RESTART, 2'd0);
        drain();
        write_reg(REG_MAZE_WIDTH, 0);
        write_reg(REG_MAZE_HEIGHT, 0);
        queue_req(ACTION_STEP, 2'd1);
        queue_req(ACTION_STEP, 2'd2);
        drain();
        write_reg(REG_MAZE_WIDTH, 3);
        write_reg(REG_MAZE_HEIGHT, 2);
        queue_req(ACTION_RESTART, 2'd2);
        queue_req(ACTION_STEP, 2'd3);
        queue_req(ACTION_STEP, 2'd2);
        queue_req(ACTION_STEP, 2'd1);
        queue_req(ACTION_STEP, 2'd0);
        queue_req(ACTION_STEP, 2'd3);
        drain();
        // shrink mid-walk
        write_reg(REG_MAZE_WIDTH, 2);
        write_reg(REG_MAZE_HEIGHT, 2);
        queue_req(ACTION_STEP, 2'd1);
        queue_req(ACTION_STEP, 2'd0);
        queue_req(ACTION_STEP, 2'd2);
        drain();
        write_reg(REG_MAZE_WIDTH, 127);
        write_reg(REG_MAZE_HEIGHT, 127);
        queue_req(ACTION_STEP, 2'd3);
        queue_req(ACTION_STEP, 2'd2);
        queue_req(ACTION_RESTART, 2'd3);
        drain();

        run_walk(4, 4, 200, 1'b0, 17);
        run_walk(64, 1, 140, 1'b1, 0);

        send_idle_pct = 63;
        recv_idle_pct = 36;
        run_walk(1, 64, 140, 1'b1, 0);
        run_walk(5, 3, 150, 1'b0, 20);
        run_walk(10, 10, 220, 1'b1, 0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_walk(2, 7, 150, 1'b1, 25);
        run_walk(6, 6, 60, 1'b1, 0);
        run_walk(3, 3, 60, 1'b0, 0);
        run_walk(8, 2, 60, 1'b0, 0);
        run_walk(127, 127, 80, 1'b1, 25);
        run_walk(16, 16, 150, 1'b0, 12);

        if (mismatches == 0)
            $display("PASS maze_backtracker_step");
        else
            $display("FAIL maze_backtracker_step");
        $finish;
    end

endmodule

`default_nettype wire
